// File: rtl/gpac_pkg.sv
`default_nettype none
package gpac_pkg;

   localparam int DIV_STAGES = 4;
   localparam int PIPE_DEPTH = 12;

   localparam logic [12:0] FRAME_DIM_MAX = 13'd4096;
   localparam logic [12:0] FRAME_WIDTH_RESET = 13'd1024;
   localparam logic [12:0] SPLIT_COLUMN_RESET = 13'd0;

   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_SPLIT_COLUMN = 1'b1;

   localparam logic [7:0] COVERAGE_FULL = 8'h40;
   localparam logic [7:0] ALPHA_FULL = 8'hff;

   typedef logic [7:0] chan_type;
   typedef logic [24:0] rem_type;
   typedef logic [15:0] den_type;
   typedef chan_type [2:0] rgb_type;
   typedef rem_type [2:0] num3_type;

   typedef struct packed {
      logic        wr;
      logic        sh;
      logic [7:0]  alpha;
      logic [7:0]  mida;
      logic [31:0] text;
   } side1_type;

   typedef struct packed {
      logic       wr;
      logic       sh;
      logic [7:0] alpha;
      logic [7:0] a_out;
   } side2_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [25:0] div_step(rem_type r, den_type d, logic [2:0] sh);
      rem_type t;
      t = rem_type'(d) << sh;
      if (r >= t) begin
         return {1'b1, r - t};
      end
      return {1'b0, r};
   endfunction

   // floor(x / 255) for x up to 255*255
   function automatic logic [7:0] div255(logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      return s[15:8];
   endfunction

   // a + b - floor(a*b/255), saturated at 255
   function automatic logic [7:0] over_alpha(logic [7:0] a, logic [7:0] b, logic [15:0] ab);
      logic [8:0] t;
      t = {1'b0, a} + {1'b0, b} - {1'b0, div255(ab)};
      return (t > 9'd255) ? ALPHA_FULL : t[7:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/gpac_div.sv
`default_nettype none
module gpac_div
   import gpac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] en,
   input  wire num3_type              num_in,
   input  wire den_type               den_in,
   output rgb_type                    quot
);

   num3_type rem_ff [DIV_STAGES];
   rgb_type  q_ff   [DIV_STAGES];
   den_type  den_ff [DIV_STAGES];

   num3_type rem_in [DIV_STAGES];
   rgb_type  q_in   [DIV_STAGES];
   den_type  den_in_s [DIV_STAGES];

   always_comb begin
      logic [25:0] r;
      rem_type     rs;
      chan_type    qs;
      den_type     ds;
      for (int s = 0; s < DIV_STAGES; s++) begin
         ds = (s == 0) ? den_in : den_ff[(s == 0) ? 0 : s - 1];
         den_in_s[s] = ds;
         for (int ch = 0; ch < 3; ch++) begin
            if (s == 0) begin
               if (num_in[ch] >= (rem_type'(den_in) << 8)) begin
                  rs = '0;
                  qs = ALPHA_FULL;
               end else begin
                  rs = num_in[ch];
                  qs = '0;
               end
            end else begin
               rs = rem_ff[(s == 0) ? 0 : s - 1][ch];
               qs = q_ff[(s == 0) ? 0 : s - 1][ch];
            end
            r = div_step(rs, ds, 3'(7 - 2 * s));
            qs[7 - 2 * s] = qs[7 - 2 * s] | r[25];
            r = div_step(r[24:0], ds, 3'(6 - 2 * s));
            qs[6 - 2 * s] = qs[6 - 2 * s] | r[25];
            rem_in[s][ch] = r[24:0];
            q_in[s][ch] = qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s] <= q_in[s];
            den_ff[s] <= den_in_s[s];
         end
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/glyph_pixel_alpha_compositor.sv
// Twelve-stage pipeline: each stage holds a valid bit and its own data registers.
// Throughput is one pixel per clock while rsp_stall is low; a stalled output holds
// its beat while empty stages behind it keep filling.
// Each over blend divides in a 4-stage restoring divider, two quotient bits a stage.
// Synchronous reset clears the valid bits, frame_width to 1024, split_column to 0.
`default_nettype none
module glyph_pixel_alpha_compositor
   import gpac_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_coverage,
   input  wire logic [31:0] req_bg_pixel,
   input  wire logic [11:0] req_column,
   input  wire logic [11:0] req_row,
   input  wire logic [31:0] req_past_color,
   input  wire logic [31:0] req_future_color,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_main_write,
   output logic [31:0]      rsp_main_pixel,
   output logic             rsp_shadow_write,
   output logic [31:0]      rsp_shadow_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_write_data
);

   logic [12:0] frame_width_ff;
   logic [12:0] split_column_ff;

   logic [PIPE_DEPTH-1:0] v_ff;
   logic [PIPE_DEPTH-1:0] en;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         split_column_ff <= SPLIT_COLUMN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: frame_width_ff <= csr_write_data;
            CSR_SPLIT_COLUMN: split_column_ff <= csr_write_data;
            default: frame_width_ff <= frame_width_ff;
         endcase
      end
   end

   always_comb begin
      en[PIPE_DEPTH-1] = !v_ff[PIPE_DEPTH-1] || !rsp_stall;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // stage 1: alpha, color select, first products
   logic [7:0]  cov_sat, alpha_in, a1_in;
   logic [12:0] width_c;
   logic [31:0] text_in;

   logic        wr1_ff, sh1_ff;
   logic [7:0]  alpha1_ff, a1_ff;
   rgb_type     bgc1_ff;
   logic [31:0] text1_ff;
   logic [15:0] pa1_ff, aa1_ff, den1_ff;

   always_comb begin
      cov_sat = (req_coverage > COVERAGE_FULL) ? COVERAGE_FULL : req_coverage;
      alpha_in = (cov_sat == COVERAGE_FULL) ? ALPHA_FULL : {cov_sat[5:0], 2'b00};
      a1_in = req_bg_pixel[31:24];
      width_c = (frame_width_ff > FRAME_DIM_MAX) ? FRAME_DIM_MAX : frame_width_ff;
      text_in = (({1'b0, req_column} < split_column_ff) ? req_past_color : req_future_color)
                | {alpha_in, 24'b0};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wr1_ff <= (req_coverage != 8'd0);
         sh1_ff <= (req_row > 12'd1) && (({1'b0, req_column} + 13'd1) < width_c);
         alpha1_ff <= alpha_in;
         a1_ff <= a1_in;
         bgc1_ff <= {req_bg_pixel[23:16], req_bg_pixel[15:8], req_bg_pixel[7:0]};
         text1_ff <= text_in;
         pa1_ff <= {8'b0, a1_in} * {8'b0, ~alpha_in};
         aa1_ff <= {8'b0, a1_in} * {8'b0, alpha_in};
         den1_ff <= {8'b0, a1_in} * 16'd255 + {8'b0, alpha_in} * {8'b0, ~a1_in};
      end
   end

   // stage 2: numerators of the black blend and its output alpha
   num3_type  num1_ff;
   den_type   den2s_ff;
   side1_type side1_ff;
   side1_type sd1_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int ch = 0; ch < 3; ch++) begin
            num1_ff[ch] <= 25'({8'b0, pa1_ff} * {16'b0, bgc1_ff[ch]});
         end
         den2s_ff <= den1_ff;
         side1_ff.wr <= wr1_ff;
         side1_ff.sh <= sh1_ff;
         side1_ff.alpha <= alpha1_ff;
         side1_ff.mida <= over_alpha(a1_ff, alpha1_ff, aa1_ff);
         side1_ff.text <= text1_ff;
      end
   end

   rgb_type mid_q;

   gpac_div u_div_black (
      .clock  (clock),
      .en     (en[5:2]),
      .num_in (num1_ff),
      .den_in (den2s_ff),
      .quot   (mid_q)
   );

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[2+s]) begin
            sd1_ff[s] <= (s == 0) ? side1_ff : sd1_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // stage 7: products of the text blend
   side1_type   sd_last;
   logic [7:0]  ta;
   logic        wr7_ff, sh7_ff;
   logic [7:0]  alpha7_ff, mida7_ff, ta7_ff;
   rgb_type     midc7_ff, tc7_ff;
   logic [15:0] p7_ff, k7_ff, den7_ff, ma7_ff;

   assign sd_last = sd1_ff[DIV_STAGES-1];
   assign ta = sd_last.text[31:24];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         wr7_ff <= sd_last.wr;
         sh7_ff <= sd_last.sh;
         alpha7_ff <= sd_last.alpha;
         mida7_ff <= sd_last.mida;
         ta7_ff <= ta;
         midc7_ff <= mid_q;
         tc7_ff <= {sd_last.text[23:16], sd_last.text[15:8], sd_last.text[7:0]};
         p7_ff <= {8'b0, sd_last.mida} * {8'b0, ~ta};
         k7_ff <= {8'b0, ta} * 16'd255;
         den7_ff <= {8'b0, sd_last.mida} * 16'd255 + {8'b0, ta} * {8'b0, ~sd_last.mida};
         ma7_ff <= {8'b0, sd_last.mida} * {8'b0, ta};
      end
   end

   // stage 8: numerators of the text blend and its output alpha
   num3_type  num2_ff;
   den_type   den8_ff;
   side2_type side2_ff;
   side2_type sd2_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int ch = 0; ch < 3; ch++) begin
            num2_ff[ch] <= 25'({8'b0, p7_ff} * {16'b0, midc7_ff[ch]})
                         + 25'({8'b0, k7_ff} * {16'b0, tc7_ff[ch]});
         end
         den8_ff <= den7_ff;
         side2_ff.wr <= wr7_ff;
         side2_ff.sh <= sh7_ff;
         side2_ff.alpha <= alpha7_ff;
         side2_ff.a_out <= over_alpha(mida7_ff, ta7_ff, ma7_ff);
      end
   end

   rgb_type out_q;

   gpac_div u_div_text (
      .clock  (clock),
      .en     (en[11:8]),
      .num_in (num2_ff),
      .den_in (den8_ff),
      .quot   (out_q)
   );

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[8+s]) begin
            sd2_ff[s] <= (s == 0) ? side2_ff : sd2_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   side2_type sd_out;
   assign sd_out = sd2_ff[DIV_STAGES-1];

   assign rsp_valid = v_ff[PIPE_DEPTH-1];
   assign rsp_main_write = sd_out.wr;
   assign rsp_shadow_write = sd_out.wr && sd_out.sh;
   assign rsp_main_pixel = sd_out.wr ? {sd_out.a_out, out_q[2], out_q[1], out_q[0]} : 32'd0;
   assign rsp_shadow_pixel = sd_out.wr ? {sd_out.alpha, 24'd0} : 32'd0;

endmodule
`default_nettype wire

// File: tb/sv/gpac_checker.sv
module gpac_checker
   import gpac_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_coverage,
   input  wire logic [31:0] req_bg_pixel,
   input  wire logic [11:0] req_column,
   input  wire logic [11:0] req_row,
   input  wire logic [31:0] req_past_color,
   input  wire logic [31:0] req_future_color,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_main_write,
   input  wire logic [31:0] rsp_main_pixel,
   input  wire logic        rsp_shadow_write,
   input  wire logic [31:0] rsp_shadow_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_write_data,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic        main_write;
      logic [31:0] main_pixel;
      logic        shadow_write;
      logic [31:0] shadow_pixel;
   } pixel_write_type;

   pixel_write_type composite_q[$];
   logic [12:0]  frame_width;
   logic [12:0]  split_column;

   function automatic logic [7:0] blend_chan(int unsigned a1, int unsigned a2,
                                             int unsigned c1, int unsigned c2);
      int unsigned num;
      int unsigned den;
      int unsigned q;
      num = a1 * c1 * (255 - a2) + 255 * a2 * c2;
      den = 255 * a1 + a2 * (255 - a1);
      if (den == 0) return 8'd0;
      q = num / den;
      return (q > 255) ? 8'hff : q[7:0];
   endfunction

   function automatic logic [31:0] blend_over(logic [31:0] p1, logic [31:0] p2);
      int unsigned a1;
      int unsigned a2;
      int unsigned a;
      a1 = p1[31:24];
      a2 = p2[31:24];
      a = a1 + a2 - (a1 * a2) / 255;
      if (a > 255) a = 255;
      return {a[7:0], blend_chan(a1, a2, p1[23:16], p2[23:16]),
              blend_chan(a1, a2, p1[15:8], p2[15:8]),
              blend_chan(a1, a2, p1[7:0], p2[7:0])};
   endfunction

   function automatic pixel_write_type composite_pixel(logic [7:0] cov, logic [31:0] bg,
                                                     logic [11:0] col, logic [11:0] row,
                                                     logic [31:0] past, logic [31:0] fut);
      pixel_write_type r;
      logic [7:0]  alpha;
      logic [31:0] shade;
      logic [31:0] mid;
      logic [31:0] text;
      int unsigned width;
      r = '0;
      if (cov == 8'd0) return r;
      width = (frame_width > FRAME_DIM_MAX) ? FRAME_DIM_MAX : frame_width;
      if (cov >= COVERAGE_FULL) alpha = ALPHA_FULL;
      else alpha = {cov[5:0], 2'b00};
      shade = {alpha, 24'd0};
      mid = blend_over(bg, shade);
      text = ((13'(col) < split_column) ? past : fut) | shade;
      r.main_write = 1'b1;
      r.main_pixel = blend_over(mid, text);
      r.shadow_write = (row > 12'd1) && (int'(col) + 1 < width);
      r.shadow_pixel = shade;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = composite_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         frame_width <= FRAME_WIDTH_RESET;
         split_column <= SPLIT_COLUMN_RESET;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FRAME_WIDTH) frame_width <= csr_write_data;
            else split_column <= csr_write_data;
         end
         if (req_valid && !req_stall)
            composite_q.push_back(composite_pixel(req_coverage, req_bg_pixel, req_column,
                                                  req_row, req_past_color,
                                                  req_future_color));
         if (rsp_valid && !rsp_stall) begin
            if (composite_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_main_pixel, 32'd0);
            end else begin
               want = composite_q.pop_front();
               if (rsp_main_write !== want.main_write)
                  report_mismatch("main_write", 32'(rsp_main_write), 32'(want.main_write));
               if (rsp_main_pixel !== want.main_pixel)
                  report_mismatch("main_pixel", rsp_main_pixel, want.main_pixel);
               if (rsp_shadow_write !== want.shadow_write)
                  report_mismatch("shadow_write", 32'(rsp_shadow_write),
                                  32'(want.shadow_write));
               if (rsp_shadow_pixel !== want.shadow_pixel)
                  report_mismatch("shadow_pixel", rsp_shadow_pixel, want.shadow_pixel);
            end
         end
      end
   end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   import gpac_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_coverage = '0;
   logic [31:0] req_bg_pixel = '0;
   logic [11:0] req_column = '0;
   logic [11:0] req_row = '0;
   logic [31:0] req_past_color = '0;
   logic [31:0] req_future_color = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_main_write;
   logic [31:0] rsp_main_pixel;
   logic        rsp_shadow_write;
   logic [31:0] rsp_shadow_pixel;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_FRAME_WIDTH;
   logic [12:0] csr_write_data = '0;
   int          fail_count;
   int          pending_count;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   glyph_pixel_alpha_compositor dut (.*);
   gpac_checker checker_i (.*);

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   task automatic write_csr(logic idx, logic [12:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pixel(logic [7:0] cov, logic [31:0] bg, logic [11:0] col,
                             logic [11:0] row, logic [31:0] past, logic [31:0] fut,
                             bit burst);
      int gap;
      gap = burst ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coverage <= cov;
      req_bg_pixel <= bg;
      req_column <= col;
      req_row <= row;
      req_past_color <= past;
      req_future_color <= fut;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic random_pixels(int count, logic [12:0] width, bit burst);
      logic [7:0] cov;
      logic [11:0] col;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: cov = 8'd0;
            1: cov = COVERAGE_FULL;
            2: cov = 8'($urandom_range(65, 255));
            default: cov = 8'($urandom_range(1, 63));
         endcase
         if ($urandom_range(0, 3) == 0 && width > 0 && width <= 4096)
            col = 12'(width - 1 - $urandom_range(0, 1));
         else
            col = 12'($urandom);
         send_pixel(cov, $urandom, col, $urandom_range(0, 3) == 0 ? 12'($urandom_range(0, 2))
                    : 12'($urandom), $urandom, $urandom, burst);
      end
   endtask

   initial begin
      int choice;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else begin
            choice = $urandom_range(0, 99);
            rsp_stall <= (choice < 25) || (choice < 28 && !stim_done);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pixel(8'd0, 32'hffffffff, 12'd5, 12'd5, 32'hffffffff, 32'hffffffff, 0);
      send_pixel(8'd64, 32'h00000000, 12'd0, 12'd0, 32'h00ffffff, 32'hff123456, 0);
      send_pixel(8'd255, 32'hffffffff, 12'd4095, 12'd4095, 32'h0, 32'h0, 0);
      send_pixel(8'd1, 32'h0, 12'd1022, 12'd2, 32'h0, 32'h00ffffff, 0);
      send_pixel(8'd63, 32'h80808080, 12'd1023, 12'd1, 32'h7f010203, 32'h55aa55aa, 0);
      send_pixel(8'd65, 32'h12345678, 12'd1024, 12'd2, 32'hffffffff, 32'h0, 0);
      send_pixel(8'd32, 32'h00ff00ff, 12'd100, 12'd3, 32'h0000ff00, 32'hff00ff00, 0);
      idle_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd4096);
      write_csr(CSR_SPLIT_COLUMN, 13'd4096);
      send_pixel(8'd40, 32'hdeadbeef, 12'd4094, 12'd9, 32'h00ff0000, 32'h000000ff, 0);
      send_pixel(8'd40, 32'hdeadbeef, 12'd4095, 12'd9, 32'h00ff0000, 32'h000000ff, 0);
      idle_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd8191);
      write_csr(CSR_SPLIT_COLUMN, 13'd10);
      send_pixel(8'd20, 32'h01020304, 12'd9, 12'd7, 32'hff0000ff, 32'h00ff00ff, 0);
      send_pixel(8'd20, 32'h01020304, 12'd10, 12'd7, 32'hff0000ff, 32'h00ff00ff, 0);
      send_pixel(8'd64, 32'hffffffff, 12'd4095, 12'd7, 32'h0, 32'h0, 0);
      idle_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd0);
      write_csr(CSR_SPLIT_COLUMN, 13'd0);
      send_pixel(8'd50, 32'h11223344, 12'd0, 12'd50, 32'h0, 32'hffffffff, 0);
      idle_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd1);
      send_pixel(8'd50, 32'h11223344, 12'd0, 12'd50, 32'h0, 32'hffffffff, 0);
      idle_drain();

      write_csr(CSR_FRAME_WIDTH, 13'd640);
      write_csr(CSR_SPLIT_COLUMN, 13'd320);
      hold_off = 1'b1;
      fork
         begin
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         random_pixels(40, 13'd640, 1);
      join
      for (int phase = 0; phase < 8; phase++) begin
         logic [12:0] w;
         logic [12:0] s;
         idle_drain();
         w = (phase % 3 == 0) ? 13'd4096 : (phase % 3 == 1) ? 13'($urandom_range(1, 8191))
             : 13'($urandom_range(1, 64));
         s = (phase == 2) ? 13'd0 : (phase == 5) ? 13'd8191 : 13'($urandom);
         write_csr(CSR_FRAME_WIDTH, w);
         write_csr(CSR_SPLIT_COLUMN, s);
         random_pixels(110, w, phase == 4);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (fail_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/gpac_pkg.sv
rtl/gpac_div.sv
rtl/glyph_pixel_alpha_compositor.sv
tb/sv/gpac_checker.sv
tb/sv/tb_top.sv
